@@ design/gmsa_pkg.sv @@
// ---------------------------------------------------------------------------
// gmsa_pkg: shared types and constants of the gray mean saturation adjuster
// Channel widths, configuration register codes, the reciprocal used to divide
// by three and the item carried between the front and back parts.
// ---------------------------------------------------------------------------
`default_nettype none

package gmsa_pkg;

  localparam int unsigned MaxChannels = 4;
  localparam int unsigned ChanW       = 16;
  localparam int unsigned SumW        = ChanW + $clog2(MaxChannels);
  localparam int unsigned CountW      = 3;
  localparam int unsigned GainW       = 16;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned QueueDepth  = 2;

  // floor(x / 3) = (x * Recip3) >> RecipShift for every x below 2**SumW
  localparam int unsigned RecipShift  = 20;
  localparam int unsigned RecipW      = 19;
  localparam logic [RecipW-1:0] Recip3 = 19'd349526;

  // signed lane widths: difference, product, shifted product, unclamped value
  localparam int unsigned DiffW = ChanW + 1;
  localparam int unsigned ProdW = 2 * DiffW;
  localparam int unsigned ValW  = ProdW - 8 + 1;

  typedef logic [ChanW-1:0]  chan_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [GainW-1:0]  gain_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgChannelCount   = 2'd0,
    CfgSaturationGain = 2'd1,
    CfgSkipIfClip     = 2'd2
  } cfg_idx_e;

  localparam count_t CountReset = 3'd3;
  localparam gain_t  GainReset  = 16'd256;
  localparam chan_t  FullScale  = 16'hFFFF;

  typedef struct packed {
    count_t count;
    gain_t  gain;
    logic   skip;
  } cfg_t;

  typedef struct packed {
    chan_t [MaxChannels-1:0] chan;
    chan_t                   gray;
    logic  [MaxChannels-1:0] active;
  } item_t;

endpackage

`default_nettype wire

@@ design/gmsa_if.sv @@
// ---------------------------------------------------------------------------
// gmsa_if: channel interfaces of the gray mean saturation adjuster
// Input beats carry one colour-table entry, output beats one adjusted entry.
// ---------------------------------------------------------------------------
`default_nettype none

interface gmsa_in_if;
  logic             valid;
  logic             ready;
  gmsa_pkg::chan_t  chan0;
  gmsa_pkg::chan_t  chan1;
  gmsa_pkg::chan_t  chan2;
  gmsa_pkg::chan_t  chan3;

  modport source (output valid, output chan0, output chan1, output chan2, output chan3,
                  input ready);
  modport sink   (input valid, input chan0, input chan1, input chan2, input chan3,
                  output ready);
endinterface

interface gmsa_out_if;
  logic             valid;
  logic             ready;
  gmsa_pkg::chan_t  out0;
  gmsa_pkg::chan_t  out1;
  gmsa_pkg::chan_t  out2;
  gmsa_pkg::chan_t  out3;
  logic             skipped;

  modport source (output valid, output out0, output out1, output out2, output out3,
                  output skipped, input ready);
  modport sink   (input valid, input out0, input out1, input out2, input out3,
                  input skipped, output ready);
endinterface

`default_nettype wire

@@ design/gmsa_front.sv @@
// ---------------------------------------------------------------------------
// gmsa_front: entry intake and gray level
// Accepts entries, marks the active channels, sums them, then divides the
// sum by the channel count to give the gray level pushed to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module gmsa_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  gmsa_in_if.sink             in_i,
  input  wire gmsa_pkg::cfg_t cfg_i,
  output gmsa_pkg::item_t     item_o,
  output logic                item_valid_o,
  input  wire logic           item_ready_i
);

  logic                                          a_valid_q, a_valid_d;
  gmsa_pkg::chan_t [gmsa_pkg::MaxChannels-1:0]   a_chan_q;
  logic [gmsa_pkg::MaxChannels-1:0]              a_active_q;
  gmsa_pkg::count_t                              a_n_q;
  logic [gmsa_pkg::SumW-1:0]                     a_sum_q;

  gmsa_pkg::chan_t [gmsa_pkg::MaxChannels-1:0]   in_chan;
  gmsa_pkg::count_t                              n_clamped;
  logic [gmsa_pkg::MaxChannels-1:0]              active;
  logic [gmsa_pkg::SumW-1:0]                     sum;
  logic                                          accept;
  logic                                          push;
  logic [gmsa_pkg::SumW+gmsa_pkg::RecipW-1:0]    prod3;
  gmsa_pkg::chan_t                               gray;

  assign in_chan = {in_i.chan3, in_i.chan2, in_i.chan1, in_i.chan0};

  // saturate the count and mark the active channels
  assign n_clamped = (cfg_i.count > gmsa_pkg::CountW'(gmsa_pkg::MaxChannels)) ?
                     gmsa_pkg::CountW'(gmsa_pkg::MaxChannels) : cfg_i.count;

  always_comb begin
    sum = '0;
    for (int i = 0; i < gmsa_pkg::MaxChannels; i++) begin
      active[i] = (gmsa_pkg::CountW'(i) < n_clamped);
      if (active[i]) begin
        sum = sum + gmsa_pkg::SumW'(in_chan[i]);
      end
    end
  end

  // advance when the stage is empty or its beat moves on to the queue
  assign push        = a_valid_q && item_ready_i;
  assign in_i.ready  = !a_valid_q || item_ready_i;
  assign accept      = in_i.valid && in_i.ready;

  always_comb begin
    a_valid_d = a_valid_q;
    if (accept) begin
      a_valid_d = 1'b1;
    end else if (push) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_chan_q   <= in_chan;
      a_active_q <= active;
      a_n_q      <= n_clamped;
      a_sum_q    <= sum;
    end
  end

  // divide the sum by the count, floored
  assign prod3 = a_sum_q * gmsa_pkg::Recip3;

  always_comb begin
    unique case (a_n_q)
      3'd1:    gray = a_sum_q[gmsa_pkg::ChanW-1:0];
      3'd2:    gray = a_sum_q[gmsa_pkg::ChanW:1];
      3'd3:    gray = prod3[gmsa_pkg::RecipShift +: gmsa_pkg::ChanW];
      3'd4:    gray = a_sum_q[gmsa_pkg::ChanW+1:2];
      default: gray = '0;
    endcase
  end

  assign item_o.chan   = a_chan_q;
  assign item_o.gray   = gray;
  assign item_o.active = a_active_q;
  assign item_valid_o  = a_valid_q;

endmodule

`default_nettype wire

@@ design/gmsa_queue.sv @@
// ---------------------------------------------------------------------------
// gmsa_queue: short item queue
// Decouples the front and back parts so each can stall on its own.
// ---------------------------------------------------------------------------
`default_nettype none

module gmsa_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire gmsa_pkg::item_t push_item_i,
  input  wire logic        push_valid_i,
  output logic             push_ready_o,
  output gmsa_pkg::item_t  pop_item_o,
  output logic             pop_valid_o,
  input  wire logic        pop_ready_i
);

  localparam int unsigned PtrW = $clog2(gmsa_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(gmsa_pkg::QueueDepth + 1);

  gmsa_pkg::item_t  mem_q [gmsa_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != CntW'(gmsa_pkg::QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  // advance the pointers, wrapping at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(gmsa_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(gmsa_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

@@ design/gmsa_back.sv @@
// ---------------------------------------------------------------------------
// gmsa_back: per-channel scaling about the gray level
// One lane per channel: multiply the offset from gray by the gain, then
// shift, re-centre, clamp, detect clipping and pick the result or the input.
// ---------------------------------------------------------------------------
`default_nettype none

module gmsa_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire gmsa_pkg::item_t item_i,
  input  wire logic        item_valid_i,
  output logic             item_ready_o,
  input  wire gmsa_pkg::cfg_t  cfg_i,
  gmsa_out_if.source       out_o
);

  logic                                              p_valid_q, p_valid_d;
  gmsa_pkg::item_t                                   p_item_q;
  logic signed [gmsa_pkg::MaxChannels-1:0][gmsa_pkg::ProdW-1:0] p_prod_q;

  logic                                              o_valid_q, o_valid_d;
  gmsa_pkg::chan_t [gmsa_pkg::MaxChannels-1:0]       o_chan_q, o_chan_d;
  logic                                              o_skipped_q, o_skipped_d;

  logic signed [gmsa_pkg::MaxChannels-1:0][gmsa_pkg::ProdW-1:0] prod;
  logic                                              pop;
  logic                                              o_load;

  // multiply lanes: offset from gray times gain
  always_comb begin
    logic signed [gmsa_pkg::DiffW-1:0] diff;
    logic signed [gmsa_pkg::DiffW-1:0] gain_s;
    gain_s = $signed({1'b0, cfg_i.gain});
    for (int i = 0; i < gmsa_pkg::MaxChannels; i++) begin
      diff    = $signed({1'b0, item_i.chan[i]}) - $signed({1'b0, item_i.gray});
      prod[i] = diff * gain_s;
    end
  end

  // advance the product stage when it is empty or moves on to the output
  assign o_load       = p_valid_q && (!o_valid_q || out_o.ready);
  assign item_ready_o = !p_valid_q || o_load;
  assign pop          = item_valid_i && item_ready_o;

  always_comb begin
    p_valid_d = p_valid_q;
    if (pop) begin
      p_valid_d = 1'b1;
    end else if (o_load) begin
      p_valid_d = 1'b0;
    end
    o_valid_d = o_valid_q;
    if (o_load) begin
      o_valid_d = 1'b1;
    end else if (out_o.ready) begin
      o_valid_d = 1'b0;
    end
  end

  // shift, re-centre, clamp and check for clipping
  always_comb begin
    logic signed [gmsa_pkg::ValW-1:0] val;
    logic                             clip;
    gmsa_pkg::chan_t [gmsa_pkg::MaxChannels-1:0] adj;
    clip = 1'b0;
    for (int i = 0; i < gmsa_pkg::MaxChannels; i++) begin
      // lane select is unsigned, so restore the sign before the floor shift
      val = $signed({{(gmsa_pkg::ValW-gmsa_pkg::ChanW){1'b0}}, p_item_q.gray})
          + gmsa_pkg::ValW'($signed(p_prod_q[i]) >>> 8);
      adj[i] = p_item_q.chan[i];
      if (p_item_q.active[i]) begin
        if (val >= $signed(gmsa_pkg::ValW'(gmsa_pkg::FullScale))) begin
          clip = 1'b1;
        end
        if (val < 0) begin
          adj[i] = '0;
        end else if (val > $signed(gmsa_pkg::ValW'(gmsa_pkg::FullScale))) begin
          adj[i] = gmsa_pkg::FullScale;
        end else begin
          adj[i] = val[gmsa_pkg::ChanW-1:0];
        end
      end
    end
    if (cfg_i.skip && clip) begin
      o_chan_d    = p_item_q.chan;
      o_skipped_d = 1'b1;
    end else begin
      o_chan_d    = adj;
      o_skipped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      p_valid_q <= p_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      p_item_q <= item_i;
      p_prod_q <= prod;
    end
    if (o_load) begin
      o_chan_q    <= o_chan_d;
      o_skipped_q <= o_skipped_d;
    end
  end

  assign out_o.valid   = o_valid_q;
  assign out_o.out0    = o_chan_q[0];
  assign out_o.out1    = o_chan_q[1];
  assign out_o.out2    = o_chan_q[2];
  assign out_o.out3    = o_chan_q[3];
  assign out_o.skipped = o_skipped_q;

`ifndef NO_ASSERTIONS
  // a skipped entry only appears with skip mode on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && o_skipped_q) |-> cfg_i.skip)
    else $error("gmsa_back: skipped flag without skip mode");

  // a beat taken from the queue lands in the product stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> p_valid_q)
    else $error("gmsa_back: popped beat lost");

  // a product beat held behind a stalled output is not dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_valid_q && o_valid_q && !out_o.ready) |=> (p_valid_q && o_valid_q))
    else $error("gmsa_back: beat dropped under stall");
`endif

endmodule

`default_nettype wire

@@ design/gray_mean_saturation_adjust_top.sv @@
// ---------------------------------------------------------------------------
// gray_mean_saturation_adjust_top: saturation scaling about the channel mean
// Configuration registers, the intake front, the item queue and the scaling
// back end.
//
//   channel  dir  payload                         handshake
//   in_i     in   chan0..chan3 (16 b each)        valid / ready
//   out_o    out  out0..out3 (16 b), skipped      valid / ready
//   cfg      in   cfg_idx_i (2 b), cfg_data_i     cfg_we_i, no back-pressure
//
// One entry is accepted per cycle and one result leaves per cycle while
// neither side stalls. Each entry passes the sum register, a queue entry,
// the product register and the output register; the four-lane multiply sets
// the back end's stage. Reset clears all valid state and loads the registers
// with count 3, gain 256 and skip mode off. Either side may stall; the
// two-entry queue and the output register hold beats without loss.
// ---------------------------------------------------------------------------
`default_nettype none

module gray_mean_saturation_adjust_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  gmsa_in_if.sink                              in_i,
  gmsa_out_if.source                           out_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [gmsa_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [gmsa_pkg::CfgDataW-1:0]   cfg_data_i
);

  gmsa_pkg::cfg_t   cfg_q, cfg_d;
  gmsa_pkg::item_t  front_item;
  logic             front_valid;
  logic             front_ready;
  gmsa_pkg::item_t  queue_item;
  logic             queue_valid;
  logic             queue_ready;

  // decode configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (gmsa_pkg::cfg_idx_e'(cfg_idx_i))
        gmsa_pkg::CfgChannelCount:   cfg_d.count = cfg_data_i[gmsa_pkg::CountW-1:0];
        gmsa_pkg::CfgSaturationGain: cfg_d.gain  = cfg_data_i[gmsa_pkg::GainW-1:0];
        gmsa_pkg::CfgSkipIfClip:     cfg_d.skip  = cfg_data_i[0];
        default:                     cfg_d       = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.count <= gmsa_pkg::CountReset;
      cfg_q.gain  <= gmsa_pkg::GainReset;
      cfg_q.skip  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  gmsa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_q),
    .item_o       (front_item),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready)
  );

  gmsa_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_item_i  (front_item),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_item_o   (queue_item),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready)
  );

  gmsa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (queue_item),
    .item_valid_i (queue_valid),
    .item_ready_o (queue_ready),
    .cfg_i        (cfg_q),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

@@ verif/gmsa_adjust_checker.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// gmsa_adjust_checker: result checker for the gray mean saturation adjuster
// Watches the entry and result channels and the register write port, keeps
// its own copy of the registers, works out the adjusted entry for every
// accepted input beat and compares each result beat, field by field, with
// the oldest outstanding expectation.
// ---------------------------------------------------------------------------

module gmsa_adjust_checker
  import gmsa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  gmsa_in_if                  in_beat_i,
  gmsa_out_if                 out_beat_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         mismatches_o,
  output int unsigned         in_flight_o,
  output int unsigned         results_checked_o
);

  typedef struct packed {
    chan_t [MaxChannels-1:0] level;
    logic                    skipped;
  } adjusted_entry_t;

  // register copy
  count_t cfg_count;
  gain_t  cfg_gain;
  logic   cfg_skip;

  adjusted_entry_t expected_results[$];
  adjusted_entry_t got;
  adjusted_entry_t want;
  int              lane;

  // Scale every active channel about the floored mean, clamp, and fall back
  // to the raw entry when skip mode is on and any lane reaches full scale.
  function automatic adjusted_entry_t adjust_entry(input chan_t [MaxChannels-1:0] raw);
    adjusted_entry_t res;
    int unsigned     active;
    int unsigned     sum;
    longint          gray;
    longint          prod;
    longint          val;
    logic            clip;
    int              i;
    active      = (cfg_count > MaxChannels) ? MaxChannels : cfg_count;
    res.level   = raw;
    res.skipped = 1'b0;
    clip        = 1'b0;
    sum         = 0;
    if (active != 0) begin
      for (i = 0; i < active; i++) sum += raw[i];
      gray = longint'(sum / active);
      for (i = 0; i < active; i++) begin
        prod = longint'(cfg_gain) * (longint'(raw[i]) - gray);
        // arithmetic shift floors toward minus infinity
        val = gray + (prod >>> 8);
        if (val >= 65535) clip = 1'b1;
        if (val < 0) begin
          res.level[i] = '0;
        end else if (val > 65535) begin
          res.level[i] = FullScale;
        end else begin
          res.level[i] = chan_t'(val);
        end
      end
    end
    if (cfg_skip && clip) begin
      res.level   = raw;
      res.skipped = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_count         = CountReset;
      cfg_gain          = GainReset;
      cfg_skip          = 1'b0;
      expected_results.delete();
      mismatches_o      = 0;
      in_flight_o       = 0;
      results_checked_o = 0;
    end else begin
      // compare the result beat first, so a result cannot match an entry accepted at the same edge
      if (out_beat_i.valid && out_beat_i.ready) begin
        got.level   = {out_beat_i.out3, out_beat_i.out2, out_beat_i.out1, out_beat_i.out0};
        got.skipped = out_beat_i.skipped;
        results_checked_o++;
        if (expected_results.size() == 0) begin
          $error("result beat with no entry outstanding: %h skipped=%b",
                 got.level, got.skipped);
          mismatches_o++;
        end else begin
          want = expected_results.pop_front();
          for (lane = 0; lane < MaxChannels; lane++) begin
            if (got.level[lane] !== want.level[lane]) begin
              $error("out%0d: expected %h, got %h", lane, want.level[lane], got.level[lane]);
              mismatches_o++;
            end
          end
          if (got.skipped !== want.skipped) begin
            $error("skipped: expected %b, got %b", want.skipped, got.skipped);
            mismatches_o++;
          end
        end
      end

      // predict the accepted entry with the registers in force before this edge
      if (in_beat_i.valid && in_beat_i.ready) begin
        expected_results.push_back(adjust_entry({in_beat_i.chan3, in_beat_i.chan2,
                                                 in_beat_i.chan1, in_beat_i.chan0}));
      end

      // mirror register writes, masked to each register's width
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgChannelCount:   cfg_count = cfg_data_i[CountW-1:0];
          CfgSaturationGain: cfg_gain  = cfg_data_i[GainW-1:0];
          CfgSkipIfClip:     cfg_skip  = cfg_data_i[0];
          default: ;
        endcase
      end

      in_flight_o = expected_results.size();
    end
  end

endmodule

@@ verif/tb_gray_mean_saturation_adjust_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_gray_mean_saturation_adjust_top: regression of the saturation adjuster
// Drives colour-table entries through a directed set of corner cases and
// then random phases under varying register settings, with random idling on
// both channels, a long output hold-off and a drain before every register
// change. A separate checker predicts and compares every result beat.
// ---------------------------------------------------------------------------

module tb_gray_mean_saturation_adjust_top;
  import gmsa_pkg::*;

  typedef chan_t [MaxChannels-1:0] entry_t;

  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned HoldOffCycles = 60;
  localparam int unsigned Phases        = 8;
  localparam int unsigned PhaseEntries  = 110;
  localparam int unsigned DrainCycles   = 12;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  int unsigned mismatches;
  int unsigned in_flight;
  int unsigned results_checked;
  int unsigned items_sent;
  int unsigned settings_applied;
  int unsigned hold_off_requests;
  int unsigned hold_offs_served;
  int unsigned cycles;
  bit          idle_enabled;

  gmsa_in_if  in_bus ();
  gmsa_out_if out_bus ();

  gray_mean_saturation_adjust_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  gmsa_adjust_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_beat_i         (in_bus),
    .out_beat_i        (out_bus),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .mismatches_o      (mismatches),
    .in_flight_o       (in_flight),
    .results_checked_o (results_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("gray_mean_saturation_adjust_top regression: fail");
    $finish;
  end

  // Result side: random stall bursts, and a long hold-off when asked for
  initial begin
    int burst;
    out_bus.ready <= 1'b0;
    hold_offs_served = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_offs_served != hold_off_requests) begin
        hold_offs_served++;
        out_bus.ready <= 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk_i);
      end else if (idle_enabled && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 7);
        out_bus.ready <= 1'b0;
        repeat (burst - 1) @(negedge clk_i);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // Drop valid, let every outstanding result drain, then load the registers
  task automatic apply_settings(input logic [CfgDataW-1:0] count_word,
                                input logic [CfgDataW-1:0] gain_word,
                                input logic [CfgDataW-1:0] skip_word);
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    wait (in_flight == 0);
    write_reg(CfgChannelCount, count_word);
    write_reg(CfgSaturationGain, gain_word);
    write_reg(CfgSkipIfClip, skip_word);
    settings_applied++;
  endtask

  // Offer one entry, possibly after an idle burst, and hold it until taken
  task automatic send_entry(input entry_t e);
    int gap;
    if (idle_enabled && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      repeat (gap) begin
        @(negedge clk_i);
        in_bus.valid <= 1'b0;
        in_bus.chan0 <= chan_t'($urandom);
        in_bus.chan1 <= chan_t'($urandom);
      end
    end
    @(negedge clk_i);
    in_bus.valid <= 1'b1;
    in_bus.chan0 <= e[0];
    in_bus.chan1 <= e[1];
    in_bus.chan2 <= e[2];
    in_bus.chan3 <= e[3];
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    items_sent++;
  endtask

  // Clustered channels in half the entries so that the scaled values stay in range, plus
  // fully random entries and entries built from the extremes
  function automatic entry_t random_entry();
    entry_t e;
    int     style;
    int     base;
    int     spread;
    int     v;
    int     i;
    style  = $urandom_range(0, 9);
    base   = int'($urandom_range(0, 65535));
    spread = $urandom_range(0, 1) ? int'($urandom_range(0, 255)) : int'($urandom_range(0, 8191));
    for (i = 0; i < MaxChannels; i++) begin
      if (style < 5) begin
        v = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        e[i] = chan_t'(v);
      end else if (style < 8) begin
        e[i] = chan_t'($urandom_range(0, 65535));
      end else begin
        case ($urandom_range(0, 2))
          0:       e[i] = '0;
          1:       e[i] = FullScale;
          default: e[i] = chan_t'($urandom_range(0, 65535));
        endcase
      end
    end
    return e;
  endfunction

  function automatic gain_t random_gain();
    case ($urandom_range(0, 3))
      0:       return gain_t'($urandom_range(0, 512));
      1:       return gain_t'($urandom_range(0, 65535));
      2:       return GainReset;
      default: return gain_t'($urandom_range(200, 320));
    endcase
  endfunction

  // Stimulus and verdict
  initial begin
    int     p;
    int     k;
    count_t cnt;
    gain_t  gain;
    logic   skip_mode;
    rst_ni           <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= '0;
    cfg_data         <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.chan0     <= '0;
    in_bus.chan1     <= '0;
    in_bus.chan2     <= '0;
    in_bus.chan3     <= '0;
    items_sent        = 0;
    settings_applied  = 0;
    hold_off_requests = 0;
    idle_enabled      = 1'b1;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: three channels, unity gain
    send_entry({16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_entry({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_entry({16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
    send_entry({16'h8000, 16'h0001, 16'h0000, 16'hFFFF});
    // no active channel: everything passes through, even in skip mode
    apply_settings(16'd0, 16'd300, 16'd1);
    send_entry({16'hABCD, 16'h0000, 16'hFFFF, 16'h1234});
    send_entry({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    // count above the channel limit saturates to four
    apply_settings(16'd7, 16'd512, 16'd0);
    send_entry({16'h4000, 16'h8000, 16'hFFFF, 16'h0000});
    send_entry({16'h0400, 16'h0300, 16'h0200, 16'h0100});
    // zero gain collapses every channel onto the gray level
    apply_settings(16'd4, 16'd0, 16'd0);
    send_entry({16'hFFFE, 16'h0001, 16'hFFFF, 16'h0000});
    send_entry({16'h0008, 16'h0007, 16'h0006, 16'h0005});
    // full gain in skip mode: clipping entry, flat entry, full-scale entry
    apply_settings(16'd4, 16'hFFFF, 16'd1);
    send_entry({16'h0001, 16'h8000, 16'hFFFF, 16'h0000});
    send_entry({16'h8000, 16'h8000, 16'h8000, 16'h8000});
    send_entry({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    // single channel: gray equals the channel itself
    apply_settings(16'd1, 16'hFFFF, 16'd1);
    send_entry({16'h0000, 16'h0000, 16'h0000, 16'hFFFF});
    send_entry({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h1234});
    // two channels, half gain
    apply_settings(16'd2, 16'd128, 16'd0);
    send_entry({16'hAAAA, 16'h5555, 16'h0000, 16'hFFFF});
    send_entry({16'h0000, 16'h0000, 16'h8001, 16'h7FFF});

    // random phases; upper bits of the narrow registers carry junk
    for (p = 0; p < Phases; p++) begin
      case (p)
        0: begin cnt = 3'd4; gain = 16'hFFFF; skip_mode = 1'b1; end
        1: begin cnt = 3'd1; gain = 16'h0000; skip_mode = 1'b0; end
        2: begin cnt = 3'd0; gain = random_gain(); skip_mode = 1'($urandom_range(0, 1)); end
        3: begin cnt = 3'd7; gain = random_gain(); skip_mode = 1'b1; end
        default: begin
          cnt       = count_t'($urandom_range(0, 7));
          gain      = random_gain();
          skip_mode = 1'($urandom_range(0, 1));
        end
      endcase
      apply_settings({13'($urandom_range(0, 8191)), cnt}, gain,
                     {15'($urandom_range(0, 32767)), skip_mode});
      // last phase runs flat out on both sides
      idle_enabled = (p != Phases - 1);
      for (k = 0; k < PhaseEntries; k++) begin
        if (p == 3 && k == 20) hold_off_requests++;
        send_entry(random_entry());
      end
    end

    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    wait (in_flight == 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d entries under %0d register settings; %0d results compared.",
             items_sent, settings_applied + 1, results_checked);
    $display("Included zero and oversized channel counts, gain extremes and skip mode.");
    if (mismatches == 0) begin
      $display("gray_mean_saturation_adjust_top regression: pass");
    end else begin
      $display("gray_mean_saturation_adjust_top regression: fail");
    end
    $finish;
  end

endmodule
